/* rtl/core/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and codes of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int ID_W = 5;
    localparam int DL_W = 63;
    localparam int IV_W = 40;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_ADD_ACTIVE  = 2'd1;
    localparam logic [1:0] ERR_CANCEL_IDLE = 2'd2;

    localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] timer_id;
        logic [DL_W-1:0] deadline;
        logic [IV_W-1:0] interval;
        logic [DL_W-1:0] current_time;
    } dtq_in_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] timer_id_res;
        logic [1:0]      error;
        logic            earliest_changed;
        logic            has_next;
        logic [DL_W-1:0] next_deadline;
        logic            last;
    } dtq_out_t;

    typedef struct packed {
        logic            lt;
        logic            le_now;
        logic [DL_W-1:0] sum_sat;
    } dtq_cmp_res_t;

endpackage

/* rtl/core/dtq_ram.sv */
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/dtq_cmp_unit.sv */
// ----------------------------------------------------------------------------
// dtq_cmp_unit
// Shared deadline compare and saturating re-arm adder.
// ----------------------------------------------------------------------------
module dtq_cmp_unit
    import dtq_pkg::*;
(
    input  logic [DL_W-1:0] a,
    input  logic [DL_W-1:0] b,
    input  logic [DL_W-1:0] now,
    input  logic [IV_W-1:0] iv,
    output dtq_cmp_res_t    res
);

    logic [DL_W:0] sum;

    assign sum         = {1'b0, a} + {{(DL_W + 1 - IV_W){1'b0}}, iv};
    assign res.lt      = (a < b);
    assign res.le_now  = (a <= now);
    assign res.sum_sat = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];

endmodule

/* rtl/core/deadline_timer_queue.sv */
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Timer slot table with ordered expiry on tick.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; results appear
// on result for one cycle each, marked by result_valid, and must be taken
// then. Slot deadlines and intervals sit in RAM with one read port, so every
// scan reads one slot per cycle. Add and cancel run one scan and give their
// result when it ends. A tick that expires k slots runs k + 2 scans and gives
// k + 1 results, one per expired slot and a closing summary, with a whole
// scan between any two of them.
// ----------------------------------------------------------------------------
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int TIMER_SLOTS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dtq_in_t  request,
    output logic     result_valid,
    output dtq_out_t result
);

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(TIMER_SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_ACK     = 5'b00100,
        ST_PICK    = 5'b01000,
        ST_SUMMARY = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    dtq_in_t                req_reg, req_next;
    logic                   err_reg, err_next;
    logic [TIMER_SLOTS-1:0] active_reg, active_next;
    logic [TIMER_SLOTS-1:0] done_reg, done_next;
    logic                   mode_min_reg, mode_min_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                   found_reg, found_next;
    logic [DL_W-1:0]        best_dl_reg, best_dl_next;
    logic [IV_W-1:0]        best_iv_reg, best_iv_next;
    logic [AW-1:0]          best_id_reg, best_id_next;
    logic                   out_valid_reg, out_valid_next;
    dtq_out_t               out_reg, out_next;

    logic [AW-1:0]   in_addr;
    logic            in_range;
    logic [AW-1:0]   req_addr;
    logic [DL_W-1:0] rd_dl;
    logic [IV_W-1:0] rd_iv;
    logic            dl_we;
    logic            iv_we;
    logic [AW-1:0]   waddr;
    logic [DL_W-1:0] dl_wdata;
    logic [DL_W-1:0] cmp_a;
    logic [DL_W-1:0] cmp_b;
    logic [IV_W-1:0] cmp_iv;
    dtq_cmp_res_t    cmp;
    logic            elig;
    logic            add_ok;

    assign in_addr  = AW'(request.timer_id);
    assign in_range = (32'(request.timer_id) < 32'(TIMER_SLOTS));
    assign req_addr = AW'(req_reg.timer_id);
    assign add_ok   = (req_reg.command == CMD_ADD) && !err_reg;

    dtq_ram #(
        .WIDTH(DL_W),
        .DEPTH(TIMER_SLOTS)
    ) u_dl_ram (
        .clk  (clk),
        .we   (dl_we),
        .waddr(waddr),
        .wdata(dl_wdata),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rd_dl)
    );

    dtq_ram #(
        .WIDTH(IV_W),
        .DEPTH(TIMER_SLOTS)
    ) u_iv_ram (
        .clk  (clk),
        .we   (iv_we),
        .waddr(waddr),
        .wdata(req_reg.interval),
        .raddr(idx_reg[AW-1:0]),
        .rdata(rd_iv)
    );

    dtq_cmp_unit u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .now(req_reg.current_time),
        .iv (cmp_iv),
        .res(cmp)
    );

    assign elig = active_reg[cmp_idx_reg]
                  && (mode_min_reg || (!done_reg[cmp_idx_reg] && cmp.le_now));

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        err_next       = err_reg;
        active_next    = active_reg;
        done_next      = done_reg;
        mode_min_next  = mode_min_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_dl_next   = best_dl_reg;
        best_iv_next   = best_iv_reg;
        best_id_next   = best_id_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        dl_we          = 1'b0;
        iv_we          = 1'b0;
        waddr          = req_addr;
        dl_wdata       = req_reg.deadline;
        cmp_a          = rd_dl;
        cmp_b          = best_dl_reg;
        cmp_iv         = best_iv_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next      = request;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    mode_min_next = 1'b1;
                    err_next      = 1'b0;
                    case (request.command)
                        CMD_ADD:
                        begin
                            err_next   = !in_range || active_reg[in_addr];
                            state_next = ST_SCAN;
                        end
                        CMD_CANCEL:
                        begin
                            err_next = !in_range || !active_reg[in_addr];
                            if (in_range && active_reg[in_addr])
                            begin
                                active_next[in_addr] = 1'b0;
                            end
                            state_next = ST_SCAN;
                        end
                        CMD_TICK:
                        begin
                            done_next     = '0;
                            mode_min_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                cmp_valid_next = (idx_reg != LAST_IDX);
                cmp_idx_next   = idx_reg[AW-1:0];
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (cmp_valid_reg && elig && (!found_reg || cmp.lt))
                begin
                    found_next   = 1'b1;
                    best_dl_next = rd_dl;
                    best_iv_next = rd_iv;
                    best_id_next = cmp_idx_reg;
                end
                if (idx_reg == LAST_IDX)
                begin
                    if (!mode_min_reg)
                    begin
                        state_next = ST_PICK;
                    end
                    else if (req_reg.command == CMD_TICK)
                    begin
                        state_next = ST_SUMMARY;
                    end
                    else
                    begin
                        state_next = ST_ACK;
                    end
                end
            end

            ST_ACK:
            begin
                cmp_a                     = req_reg.deadline;
                out_valid_next            = 1'b1;
                out_next.kind             = KIND_ACK;
                out_next.timer_id_res     = req_reg.timer_id;
                out_next.error            = ERR_NONE;
                out_next.earliest_changed = 1'b0;
                out_next.has_next         = found_reg;
                out_next.next_deadline    = found_reg ? best_dl_reg : '0;
                out_next.last             = 1'b1;
                if (err_reg)
                begin
                    out_next.error = (req_reg.command == CMD_ADD) ? ERR_ADD_ACTIVE
                                                                  : ERR_CANCEL_IDLE;
                end
                if (add_ok)
                begin
                    dl_we                 = 1'b1;
                    iv_we                 = 1'b1;
                    active_next[req_addr] = 1'b1;
                    out_next.has_next     = 1'b1;
                    if (!found_reg || cmp.lt)
                    begin
                        out_next.earliest_changed = 1'b1;
                        out_next.next_deadline    = req_reg.deadline;
                    end
                end
                state_next = ST_IDLE;
            end

            ST_PICK:
            begin
                cmp_a      = best_dl_reg;
                idx_next   = '0;
                found_next = 1'b0;
                state_next = ST_SCAN;
                if (found_reg)
                begin
                    out_valid_next            = 1'b1;
                    out_next.kind             = KIND_EXPIRED;
                    out_next.timer_id_res     = ID_W'(best_id_reg);
                    out_next.error            = ERR_NONE;
                    out_next.earliest_changed = 1'b0;
                    out_next.has_next         = 1'b0;
                    out_next.next_deadline    = '0;
                    out_next.last             = 1'b0;
                    done_next[best_id_reg]    = 1'b1;
                    if (best_iv_reg == '0)
                    begin
                        active_next[best_id_reg] = 1'b0;
                    end
                    else
                    begin
                        dl_we    = 1'b1;
                        waddr    = best_id_reg;
                        dl_wdata = cmp.sum_sat;
                    end
                end
                else
                begin
                    mode_min_next = 1'b1;
                end
            end

            ST_SUMMARY:
            begin
                out_valid_next            = 1'b1;
                out_next.kind             = KIND_SUMMARY;
                out_next.timer_id_res     = '0;
                out_next.error            = ERR_NONE;
                out_next.earliest_changed = 1'b0;
                out_next.has_next         = found_reg;
                out_next.next_deadline    = found_reg ? best_dl_reg : '0;
                out_next.last             = 1'b1;
                state_next                = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            done_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            done_reg      <= done_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        err_reg      <= err_next;
        mode_min_reg <= mode_min_next;
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        best_dl_reg  <= best_dl_next;
        best_iv_reg  <= best_iv_next;
        best_id_reg  <= best_id_next;
        out_reg      <= out_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* tb/deadline_timer_queue_test.sv */
// ----------------------------------------------------------------------------
// deadline_timer_queue_test
// Self-checking testbench of the deadline timer queue.
// ----------------------------------------------------------------------------
// Drives add, cancel and tick commands through the start/busy handshake and
// predicts every result from a behavioral copy of the slot table kept here.
// Each result strobe is compared field by field with the oldest prediction.
// Directed cases cover errors, equal deadlines, re-arm saturation and a full
// table expiring at once; a long random phase follows with a moving clock.
// ----------------------------------------------------------------------------
module deadline_timer_queue_test;
    import dtq_pkg::*;

    localparam int TIMER_SLOTS   = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * (TIMER_SLOTS + 2);
    localparam int RANDOM_ITEMS  = 390;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    dtq_in_t  request;
    logic     result_valid;
    dtq_out_t result;

    deadline_timer_queue #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .result_valid(result_valid),
        .result      (result)
    );

    bit                slot_armed  [TIMER_SLOTS];
    logic [DL_W-1:0]   slot_expiry [TIMER_SLOTS];
    logic [IV_W-1:0]   slot_period [TIMER_SLOTS];
    dtq_out_t          timer_replies[$];

    int  mismatch_count;
    int  stall_cycles;
    bit  idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DL_W:0] earliest_armed();
        logic [DL_W:0] best;
        best = '0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            if (slot_armed[i] && (!best[DL_W] || slot_expiry[i] < best[DL_W-1:0]))
                best = {1'b1, slot_expiry[i]};
        end
        return best;
    endfunction

    task automatic compute_timer_replies(input dtq_in_t item);
        dtq_out_t                r;
        logic [DL_W:0]           head;
        logic [63:0]             sum;
        bit [TIMER_SLOTS-1:0]    due;
        int                      pick;
        r = '0;
        case (item.command)
            CMD_ADD, CMD_CANCEL:
            begin
                r.kind = KIND_ACK;
                r.timer_id_res = item.timer_id;
                if (item.command == CMD_ADD)
                begin
                    if (slot_armed[item.timer_id])
                        r.error = ERR_ADD_ACTIVE;
                    else
                    begin
                        head = earliest_armed();
                        r.earliest_changed = !head[DL_W] || item.deadline < head[DL_W-1:0];
                        slot_armed[item.timer_id]  = 1'b1;
                        slot_expiry[item.timer_id] = item.deadline;
                        slot_period[item.timer_id] = item.interval;
                    end
                end
                else if (!slot_armed[item.timer_id])
                    r.error = ERR_CANCEL_IDLE;
                else
                    slot_armed[item.timer_id] = 1'b0;
                head = earliest_armed();
                r.has_next = head[DL_W];
                r.next_deadline = head[DL_W-1:0];
                r.last = 1'b1;
                timer_replies.push_back(r);
            end
            CMD_TICK:
            begin
                for (int i = 0; i < TIMER_SLOTS; i++)
                    due[i] = slot_armed[i] && slot_expiry[i] <= item.current_time;
                forever
                begin
                    pick = -1;
                    for (int i = 0; i < TIMER_SLOTS; i++)
                    begin
                        if (due[i] && (pick < 0 || slot_expiry[i] < slot_expiry[pick]))
                            pick = i;
                    end
                    if (pick < 0)
                        break;
                    due[pick] = 1'b0;
                    r = '0;
                    r.kind = KIND_EXPIRED;
                    r.timer_id_res = pick[ID_W-1:0];
                    timer_replies.push_back(r);
                    if (slot_period[pick] == '0)
                        slot_armed[pick] = 1'b0;
                    else
                    begin
                        sum = {1'b0, slot_expiry[pick]} + {24'd0, slot_period[pick]};
                        slot_expiry[pick] = sum[DL_W] ? DL_MAX : sum[DL_W-1:0];
                    end
                end
                head = earliest_armed();
                r = '0;
                r.kind = KIND_SUMMARY;
                r.has_next = head[DL_W];
                r.next_deadline = head[DL_W-1:0];
                r.last = 1'b1;
                timer_replies.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            note_mismatch($sformatf("%s expected 0x%0h actual 0x%0h", name, want, got));
    endtask

    always @(posedge clk)
    begin : check_results
        dtq_out_t want;
        bit       active;
        if (rst_n)
        begin
            active = 1'b0;
            if (result_valid)
            begin
                active = 1'b1;
                if (timer_replies.size() == 0)
                    note_mismatch($sformatf("unexpected result 0x%0h", result));
                else
                begin
                    want = timer_replies.pop_front();
                    check_field("kind", 64'(want.kind), 64'(result.kind));
                    check_field("timer_id_res", 64'(want.timer_id_res),
                                64'(result.timer_id_res));
                    check_field("error", 64'(want.error), 64'(result.error));
                    check_field("earliest_changed", 64'(want.earliest_changed),
                                64'(result.earliest_changed));
                    check_field("has_next", 64'(want.has_next), 64'(result.has_next));
                    check_field("next_deadline", 64'(want.next_deadline),
                                64'(result.next_deadline));
                    check_field("last", 64'(want.last), 64'(result.last));
                end
            end
            if (start && !busy)
            begin
                active = 1'b1;
                compute_timer_replies(request);
            end
            stall_cycles = active ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [DL_W-1:0] rand_wide();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[DL_W-1:0];
    endfunction

    function automatic dtq_in_t pack_request(input logic [1:0] cmd,
                                             input logic [ID_W-1:0] id,
                                             input logic [DL_W-1:0] dl,
                                             input logic [IV_W-1:0] iv,
                                             input logic [DL_W-1:0] now_us);
        dtq_in_t item;
        item.command      = cmd;
        item.timer_id     = id;
        item.deadline     = dl;
        item.interval     = iv;
        item.current_time = now_us;
        return item;
    endfunction

    task automatic send_item(input dtq_in_t item);
        while (idle_on && $urandom_range(99) < 21)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (timer_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [IV_W-1:0] iv_max;
        iv_max = '1;
        send_item(pack_request(CMD_TICK, 5'd0, '0, '0, '0));
        send_item(pack_request(CMD_CANCEL, 5'd0, '0, '0, '0));
        send_item(pack_request(CMD_ADD, 5'd0, 63'd100, '0, '0));
        send_item(pack_request(CMD_ADD, 5'd0, 63'd40, 40'd7, '0));
        send_item(pack_request(CMD_ADD, 5'd31, 63'd100, '0, '0));
        send_item(pack_request(CMD_ADD, 5'd5, 63'd50, 40'd30, '0));
        send_item(pack_request(CMD_ADD, 5'd7, DL_MAX - 63'd5, iv_max, '0));
        send_item(pack_request(CMD_ADD, 5'd8, '0, '0, '0));
        send_item(pack_request(CMD_UNUSED, '1, DL_MAX, iv_max, DL_MAX));
        send_item(pack_request(CMD_TICK, 5'd0, '0, '0, 63'd100));
        send_item(pack_request(CMD_CANCEL, 5'd5, '0, '0, '0));
        send_item(pack_request(CMD_CANCEL, 5'd5, '0, '0, '0));
        send_item(pack_request(CMD_TICK, 5'd0, '0, '0, DL_MAX));
        send_item(pack_request(CMD_TICK, 5'd0, '0, '0, DL_MAX));
        send_item(pack_request(CMD_CANCEL, 5'd7, '0, '0, '0));
        send_item(pack_request(CMD_CANCEL, 5'd31, '0, '0, '0));
        wait_drain();
    endtask

    task automatic test_full_table();
        logic [IV_W-1:0] iv;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            iv = (i % 3 == 0) ? '0 : IV_W'($urandom_range(1, 50));
            send_item(pack_request(CMD_ADD, i[ID_W-1:0],
                                   DL_W'(10000 + $urandom_range(0, 20)), iv, '0));
        end
        send_item(pack_request(CMD_TICK, 5'd0, '0, '0, 63'd20000));
        for (int i = 0; i < TIMER_SLOTS; i++)
            send_item(pack_request(CMD_CANCEL, i[ID_W-1:0], '0, '0, '0));
        wait_drain();
    endtask

    task automatic test_random();
        logic [DL_W-1:0] now_us;
        logic [DL_W-1:0] wide;
        logic [IV_W-1:0] iv;
        int              pick;
        now_us = 63'd1000;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_on = (n < 150) || (n >= 280);
            if (n % 100 == 99)
                wait_drain();
            pick = $urandom_range(99);
            wide = rand_wide();
            if (pick < 38)
            begin
                iv = ($urandom_range(99) < 40) ? '0 : IV_W'($urandom_range(1, 200));
                send_item(pack_request(CMD_ADD, ID_W'($urandom_range(TIMER_SLOTS - 1)),
                                       now_us + DL_W'($urandom_range(0, 300)), iv, wide));
            end
            else if (pick < 60)
                send_item(pack_request(CMD_CANCEL, ID_W'($urandom_range(TIMER_SLOTS - 1)),
                                       wide, wide[IV_W-1:0], wide));
            else if (pick < 85)
            begin
                now_us = now_us + DL_W'($urandom_range(0, 120));
                send_item(pack_request(CMD_TICK, ID_W'($urandom), wide,
                                       wide[IV_W-1:0], now_us));
            end
            else if (pick < 89)
                send_item(pack_request(CMD_UNUSED, ID_W'($urandom), wide,
                                       wide[IV_W-1:0], rand_wide()));
            else if (pick < 94)
                send_item(pack_request(CMD_TICK, ID_W'($urandom), '0, '0,
                                       ($urandom_range(1)) ? wide
                                       : now_us - DL_W'($urandom_range(0, 50))));
            else
            begin
                iv = wide[IV_W-1:0];
                send_item(pack_request(CMD_ADD, ID_W'($urandom), rand_wide(),
                                       ($urandom_range(1)) ? iv : ~iv, rand_wide()));
            end
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        stall_cycles   = 0;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            slot_armed[i]  = 1'b0;
            slot_expiry[i] = '0;
            slot_period[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && timer_replies.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
